// ===== src/yvr_pkg.sv =====
// ----------------------------------------------------------------------------
// yvr_pkg: shared types and constants of the yaw select velocity rotator
// codes, fixed-point constants, the arctangent table and the sequencer types
// ----------------------------------------------------------------------------
package yvr_pkg;

	// number of cordic rotation steps, table holds up to 24
	localparam int ANGLE_STEPS_DEF = 16;
	localparam int ATAN_TABLE_SIZE = 24;
	localparam int ATAN_IDX_W      = 5;

	// angle accumulator, Q.24 radians, holds -yaw * 2048 for any 16-bit yaw
	localparam int ANGLE_W = 28;
	// rotation accumulator, Q.30 fraction on 16-bit velocities plus growth
	localparam int ACC_W   = 50;

	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24     = 28'sd26353589;
	localparam logic signed [ANGLE_W-1:0] NEG_HALF_PI_Q24 = -28'sd26353589;
	localparam logic signed [30:0]        CORDIC_GAIN_Q30 = 31'sd652032874;

	// configuration register indexes and reset values
	localparam logic [1:0] REG_CTRL_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_SYNC_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_ZERO_BAND    = 2'd2;

	localparam logic [15:0] CTRL_TIMEOUT_RST = 16'd500;
	localparam logic [15:0] SYNC_TIMEOUT_RST = 16'd200;
	localparam logic [9:0]  ZERO_BAND_RST    = 10'd1;

	// event kinds
	localparam logic [1:0] ACT_VEL  = 2'd0;
	localparam logic [1:0] ACT_ODOM = 2'd1;
	localparam logic [1:0] ACT_PLAN = 2'd2;
	localparam logic [1:0] ACT_SYNC = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_QUAD,
		ST_MUL_X,
		ST_MUL_Y,
		ST_ITER,
		ST_FINISH
	} fsm_state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_QUAD,
		OP_MUL_X,
		OP_MUL_Y,
		OP_STEP
	} cordic_op_t;

	typedef struct packed {
		logic quad_done;
		logic last_step;
	} cordic_stat_t;

	// atan(2^-i) in Q.24
	function automatic logic signed [ANGLE_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [ANGLE_W-1:0] v;
		case (idx)
			5'd0:    v = 28'sd13176795;
			5'd1:    v = 28'sd7778716;
			5'd2:    v = 28'sd4110060;
			5'd3:    v = 28'sd2086331;
			5'd4:    v = 28'sd1047214;
			5'd5:    v = 28'sd524117;
			5'd6:    v = 28'sd262123;
			5'd7:    v = 28'sd131069;
			5'd8:    v = 28'sd65536;
			5'd9:    v = 28'sd32768;
			5'd10:   v = 28'sd16384;
			5'd11:   v = 28'sd8192;
			5'd12:   v = 28'sd4096;
			5'd13:   v = 28'sd2048;
			5'd14:   v = 28'sd1024;
			5'd15:   v = 28'sd512;
			5'd16:   v = 28'sd256;
			5'd17:   v = 28'sd128;
			5'd18:   v = 28'sd64;
			5'd19:   v = 28'sd32;
			5'd20:   v = 28'sd16;
			5'd21:   v = 28'sd8;
			5'd22:   v = 28'sd4;
			5'd23:   v = 28'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/yvr_if.sv =====
// ----------------------------------------------------------------------------
// yvr_if: event and result channels
// valid/ready channels, a beat moves when valid and ready are both high
// ----------------------------------------------------------------------------
interface yvr_evt_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [31:0]        event_time_ms;
	logic [47:0]        pose_stamp_us;
	logic signed [15:0] yaw_angle;
	logic signed [15:0] lin_x;
	logic signed [15:0] lin_y;
	logic signed [15:0] lin_z;
	logic signed [15:0] ang_x;
	logic signed [15:0] ang_y;
	logic signed [15:0] ang_z;

	modport source (
		output valid, action, event_time_ms, pose_stamp_us, yaw_angle,
		output lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
		input  ready
	);
	modport sink (
		input  valid, action, event_time_ms, pose_stamp_us, yaw_angle,
		input  lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
		output ready
	);
endinterface

interface yvr_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_lin_x;
	logic signed [15:0] out_lin_y;
	logic signed [15:0] out_lin_z;
	logic signed [15:0] out_ang_x;
	logic signed [15:0] out_ang_y;
	logic signed [15:0] out_ang_z;
	logic               used_synced;

	modport source (
		output valid, out_lin_x, out_lin_y, out_lin_z,
		output out_ang_x, out_ang_y, out_ang_z, used_synced,
		input  ready
	);
	modport sink (
		input  valid, out_lin_x, out_lin_y, out_lin_z,
		input  out_ang_x, out_ang_y, out_ang_z, used_synced,
		output ready
	);
endinterface

// ===== src/yvr_select.sv =====
// ----------------------------------------------------------------------------
// yvr_select: dead band test and yaw source choice for one velocity command
// ----------------------------------------------------------------------------
module yvr_select (
	input  logic [15:0]        ctrl_timeout,
	input  logic [15:0]        sync_timeout,
	input  logic [9:0]         zero_band,
	input  logic               plan_seen,
	input  logic [31:0]        plan_time,
	input  logic               synced_valid,
	input  logic signed [15:0] synced_heading,
	input  logic [47:0]        synced_stamp,
	input  logic [31:0]        synced_arrival,
	input  logic signed [15:0] odom_heading,
	input  logic [47:0]        odom_stamp,
	input  logic [31:0]        now,
	input  logic signed [15:0] comp [6],
	output logic               dead,
	output logic               use_sync,
	output logic signed [15:0] yaw
);

	logic [31:0] ctrl_age;
	logic [31:0] sync_age;
	logic        ctrl_active;
	logic        sync_recent;
	logic        sync_fresh;
	logic [5:0]  below;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			logic [16:0] ext;
			logic [16:0] mag;
			ext = {comp[k][15], comp[k]};
			mag = comp[k][15] ? (17'd0 - ext) : ext;
			below[k] = mag < {7'd0, zero_band};
		end
	end

	assign dead        = &below;
	assign ctrl_age    = now - plan_time;
	assign sync_age    = now - synced_arrival;
	assign ctrl_active = plan_seen && (ctrl_age <= {16'd0, ctrl_timeout});
	assign sync_recent = synced_valid && (sync_age <= {16'd0, sync_timeout});
	assign sync_fresh  = synced_valid && (synced_stamp >= odom_stamp);
	assign use_sync    = ctrl_active && sync_recent && sync_fresh;
	assign yaw         = use_sync ? synced_heading : odom_heading;

endmodule

// ===== src/yvr_cordic.sv =====
// ----------------------------------------------------------------------------
// yvr_cordic: shared rotation datapath
// quarter turn reduction, gain multiply and one cordic step per cycle
// ----------------------------------------------------------------------------
module yvr_cordic #(
	parameter int ANGLE_STEPS = yvr_pkg::ANGLE_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  yvr_pkg::cordic_op_t  op,
	input  logic signed [15:0]   yaw,
	input  logic signed [15:0]   lin_x,
	input  logic signed [15:0]   lin_y,
	output yvr_pkg::cordic_stat_t stat,
	output logic signed [15:0]   res_x,
	output logic signed [15:0]   res_y
);

	localparam int AW = yvr_pkg::ACC_W;
	localparam int TW = yvr_pkg::ANGLE_W;
	localparam int SW = $clog2(ANGLE_STEPS);

	logic signed [AW-1:0] x_q;
	logic signed [AW-1:0] y_q;
	logic signed [TW-1:0] t_q;
	logic [SW-1:0]        step_q;

	logic signed [TW-1:0] t_init;
	logic signed [16:0]   mul_a;
	logic signed [47:0]   prod;
	logic signed [AW-1:0] prod_ext;
	logic signed [AW-1:0] dx;
	logic signed [AW-1:0] dy;
	logic signed [TW-1:0] atan_v;

	function automatic logic signed [15:0] round_sat(input logic signed [AW-1:0] v);
		logic signed [AW-1:0]    r;
		logic signed [AW-31:0]   q;
		logic signed [15:0]      o;
		r = v + (AW'(1) <<< 29);
		q = r[AW-1:30];
		if (q > (AW-30)'(32767))
			o = 16'sh7fff;
		else if (q < -(AW-30)'(32768))
			o = 16'sh8000;
		else
			o = q[15:0];
		return o;
	endfunction

	// angle is -yaw in Q.24
	assign t_init   = -({{(TW-16){yaw[15]}}, yaw} <<< 11);
	assign mul_a    = (op == yvr_pkg::OP_MUL_Y) ? y_q[16:0] : x_q[16:0];
	assign prod     = mul_a * yvr_pkg::CORDIC_GAIN_Q30;
	assign prod_ext = {{(AW-48){prod[47]}}, prod};
	assign dx       = y_q >>> step_q;
	assign dy       = x_q >>> step_q;
	assign atan_v   = yvr_pkg::atan_q24(yvr_pkg::ATAN_IDX_W'(step_q));

	assign stat.quad_done = !(t_q > yvr_pkg::HALF_PI_Q24) && !(t_q < yvr_pkg::NEG_HALF_PI_Q24);
	assign stat.last_step = step_q == SW'(ANGLE_STEPS - 1);

	assign res_x = round_sat(x_q);
	assign res_y = round_sat(y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			case (op)
				yvr_pkg::OP_LOAD: step_q <= '0;
				yvr_pkg::OP_STEP: step_q <= step_q + 1'b1;
				default:          step_q <= step_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			yvr_pkg::OP_LOAD: begin
				x_q <= {{(AW-16){lin_x[15]}}, lin_x};
				y_q <= {{(AW-16){lin_y[15]}}, lin_y};
				t_q <= t_init;
			end
			yvr_pkg::OP_QUAD: begin
				// one quarter turn a cycle until the angle is within half pi
				if (t_q > yvr_pkg::HALF_PI_Q24) begin
					x_q <= -y_q;
					y_q <= x_q;
					t_q <= t_q - yvr_pkg::HALF_PI_Q24;
				end else if (t_q < yvr_pkg::NEG_HALF_PI_Q24) begin
					x_q <= y_q;
					y_q <= -x_q;
					t_q <= t_q + yvr_pkg::HALF_PI_Q24;
				end
			end
			yvr_pkg::OP_MUL_X: x_q <= prod_ext;
			yvr_pkg::OP_MUL_Y: y_q <= prod_ext;
			yvr_pkg::OP_STEP: begin
				if (!t_q[TW-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					t_q <= t_q - atan_v;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					t_q <= t_q + atan_v;
				end
			end
			yvr_pkg::OP_HOLD: ;
			default: ;
		endcase
	end

endmodule

// ===== src/yaw_select_velocity_rotator_core.sv =====
// ----------------------------------------------------------------------------
// yaw_select_velocity_rotator_core: rotates planar velocity commands by yaw
// keeps odometry, plan hint and synced odometry state, rotates lin_x/lin_y
// ----------------------------------------------------------------------------
// Odometry, plan hint and synced odometry beats update internal state in the
// cycle they are accepted and produce no result; the block is ready again at
// once. A velocity command takes the block out of service until its result
// sits in the output register: the yaw is picked and the dead band tested,
// then come the quarter-turn reduction, the cordic gain multiply of x and then
// of y on the one shared 17x31 multiplier, the cordic steps, and the round and
// saturate into the output register. A dead band command goes straight from
// the decision to the output register, and a command with no odometry yet is
// dropped after the decision. The result register parts the two sides, so the
// next event beat is taken while a result still waits for the sink; a
// following command stalls in its finish state only if that result has not
// left yet.
// ----------------------------------------------------------------------------
module yaw_select_velocity_rotator_core #(
	parameter int ANGLE_STEPS = yvr_pkg::ANGLE_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	yvr_evt_if.sink     evt,
	yvr_res_if.source   res
);

	// configuration registers
	logic [15:0] ctrl_timeout_q;
	logic [15:0] sync_timeout_q;
	logic [9:0]  zero_band_q;

	// event state
	logic               odom_valid_q;
	logic signed [15:0] odom_heading_q;
	logic [47:0]        odom_stamp_q;
	logic               plan_seen_q;
	logic [31:0]        plan_time_q;
	logic               synced_valid_q;
	logic signed [15:0] synced_heading_q;
	logic [47:0]        synced_stamp_q;
	logic [31:0]        synced_arrival_q;

	// latched command
	logic [31:0]        now_q;
	logic signed [15:0] comp_q [6];

	// sequencer
	yvr_pkg::fsm_state_t   state_q;
	yvr_pkg::fsm_state_t   state_d;
	yvr_pkg::cordic_op_t   op;
	yvr_pkg::cordic_stat_t cstat;
	logic                  evt_ready;
	logic                  res_wr;
	logic                  out_free;
	logic                  evt_fire;

	// decision
	logic               dead;
	logic               use_sync;
	logic signed [15:0] yaw;
	logic               dead_q;
	logic               use_sync_q;
	logic signed [15:0] rot_x;
	logic signed [15:0] rot_y;

	// result register
	logic               res_valid_q;
	logic signed [15:0] out_lin_x_q;
	logic signed [15:0] out_lin_y_q;
	logic signed [15:0] out_lin_z_q;
	logic signed [15:0] out_ang_x_q;
	logic signed [15:0] out_ang_y_q;
	logic signed [15:0] out_ang_z_q;
	logic               used_synced_q;

	assign evt_fire = evt.valid && evt_ready;
	assign out_free = !res_valid_q || res.ready;

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_timeout_q <= yvr_pkg::CTRL_TIMEOUT_RST;
			sync_timeout_q <= yvr_pkg::SYNC_TIMEOUT_RST;
			zero_band_q    <= yvr_pkg::ZERO_BAND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				yvr_pkg::REG_CTRL_TIMEOUT: ctrl_timeout_q <= cfg_data;
				yvr_pkg::REG_SYNC_TIMEOUT: sync_timeout_q <= cfg_data;
				yvr_pkg::REG_ZERO_BAND:    zero_band_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// event state updates on accepted beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odom_valid_q     <= 1'b0;
			odom_heading_q   <= '0;
			odom_stamp_q     <= '0;
			plan_seen_q      <= 1'b0;
			plan_time_q      <= '0;
			synced_valid_q   <= 1'b0;
			synced_heading_q <= '0;
			synced_stamp_q   <= '0;
			synced_arrival_q <= '0;
		end else if (evt_fire) begin
			unique case (evt.action)
				yvr_pkg::ACT_ODOM: begin
					odom_valid_q   <= 1'b1;
					odom_heading_q <= evt.yaw_angle;
					odom_stamp_q   <= evt.pose_stamp_us;
				end
				yvr_pkg::ACT_PLAN: begin
					plan_seen_q <= 1'b1;
					plan_time_q <= evt.event_time_ms;
				end
				yvr_pkg::ACT_SYNC: begin
					// synced odometry also seeds an empty odometry slot
					if (!odom_valid_q) begin
						odom_valid_q   <= 1'b1;
						odom_heading_q <= evt.yaw_angle;
						odom_stamp_q   <= evt.pose_stamp_us;
					end
					synced_valid_q   <= 1'b1;
					synced_heading_q <= evt.yaw_angle;
					synced_stamp_q   <= evt.pose_stamp_us;
					synced_arrival_q <= evt.event_time_ms;
				end
				default: ;
			endcase
		end
	end

	// command capture, held for the whole rotation
	always_ff @(posedge clk) begin
		if (evt_fire && evt.action == yvr_pkg::ACT_VEL) begin
			now_q     <= evt.event_time_ms;
			comp_q[0] <= evt.lin_x;
			comp_q[1] <= evt.lin_y;
			comp_q[2] <= evt.lin_z;
			comp_q[3] <= evt.ang_x;
			comp_q[4] <= evt.ang_y;
			comp_q[5] <= evt.ang_z;
		end
		if (state_q == yvr_pkg::ST_DECIDE) begin
			dead_q     <= dead;
			use_sync_q <= use_sync;
		end
	end

	yvr_select u_select (
		.ctrl_timeout   (ctrl_timeout_q),
		.sync_timeout   (sync_timeout_q),
		.zero_band      (zero_band_q),
		.plan_seen      (plan_seen_q),
		.plan_time      (plan_time_q),
		.synced_valid   (synced_valid_q),
		.synced_heading (synced_heading_q),
		.synced_stamp   (synced_stamp_q),
		.synced_arrival (synced_arrival_q),
		.odom_heading   (odom_heading_q),
		.odom_stamp     (odom_stamp_q),
		.now            (now_q),
		.comp           (comp_q),
		.dead           (dead),
		.use_sync       (use_sync),
		.yaw            (yaw)
	);

	yvr_cordic #(
		.ANGLE_STEPS (ANGLE_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.yaw    (yaw),
		.lin_x  (comp_q[0]),
		.lin_y  (comp_q[1]),
		.stat   (cstat),
		.res_x  (rot_x),
		.res_y  (rot_y)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= yvr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			yvr_pkg::ST_IDLE: begin
				if (evt_fire && evt.action == yvr_pkg::ACT_VEL)
					state_d = yvr_pkg::ST_DECIDE;
			end
			yvr_pkg::ST_DECIDE: begin
				// dead band wins even before odometry, else drop without odometry
				if (dead)
					state_d = yvr_pkg::ST_FINISH;
				else if (!odom_valid_q)
					state_d = yvr_pkg::ST_IDLE;
				else
					state_d = yvr_pkg::ST_QUAD;
			end
			yvr_pkg::ST_QUAD: begin
				if (cstat.quad_done)
					state_d = yvr_pkg::ST_MUL_X;
			end
			yvr_pkg::ST_MUL_X: state_d = yvr_pkg::ST_MUL_Y;
			yvr_pkg::ST_MUL_Y: state_d = yvr_pkg::ST_ITER;
			yvr_pkg::ST_ITER: begin
				if (cstat.last_step)
					state_d = yvr_pkg::ST_FINISH;
			end
			yvr_pkg::ST_FINISH: begin
				if (out_free)
					state_d = yvr_pkg::ST_IDLE;
			end
			default: state_d = yvr_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		op        = yvr_pkg::OP_HOLD;
		evt_ready = 1'b0;
		res_wr    = 1'b0;
		unique case (state_q)
			yvr_pkg::ST_IDLE:   evt_ready = 1'b1;
			yvr_pkg::ST_DECIDE: op = yvr_pkg::OP_LOAD;
			yvr_pkg::ST_QUAD:   op = yvr_pkg::OP_QUAD;
			yvr_pkg::ST_MUL_X:  op = yvr_pkg::OP_MUL_X;
			yvr_pkg::ST_MUL_Y:  op = yvr_pkg::OP_MUL_Y;
			yvr_pkg::ST_ITER:   op = yvr_pkg::OP_STEP;
			yvr_pkg::ST_FINISH: res_wr = out_free;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (res_wr)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_wr) begin
			if (dead_q) begin
				out_lin_x_q   <= '0;
				out_lin_y_q   <= '0;
				out_lin_z_q   <= '0;
				out_ang_x_q   <= '0;
				out_ang_y_q   <= '0;
				out_ang_z_q   <= '0;
				used_synced_q <= 1'b0;
			end else begin
				out_lin_x_q   <= rot_x;
				out_lin_y_q   <= rot_y;
				out_lin_z_q   <= comp_q[2];
				out_ang_x_q   <= comp_q[3];
				out_ang_y_q   <= comp_q[4];
				out_ang_z_q   <= comp_q[5];
				used_synced_q <= use_sync_q;
			end
		end
	end

	assign evt.ready       = evt_ready;
	assign res.valid       = res_valid_q;
	assign res.out_lin_x   = out_lin_x_q;
	assign res.out_lin_y   = out_lin_y_q;
	assign res.out_lin_z   = out_lin_z_q;
	assign res.out_ang_x   = out_ang_x_q;
	assign res.out_ang_y   = out_ang_y_q;
	assign res.out_ang_z   = out_ang_z_q;
	assign res.used_synced = used_synced_q;

	// a dead band beat leaves as all zeros with the odometry yaw flag clear
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == yvr_pkg::ST_FINISH && dead_q && out_free) |=>
		(res.valid && res.out_lin_x == 16'sd0 && res.out_lin_y == 16'sd0 &&
		 res.used_synced == 1'b0))
		else $error("dead band result not zero");

	// quarter turn reduction always ends with the angle within half pi
	a_quad_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == yvr_pkg::ST_QUAD && $past(state_q == yvr_pkg::ST_QUAD) &&
		 $past(state_q == yvr_pkg::ST_QUAD, 2)) |-> cstat.quad_done)
		else $error("quarter turn reduction did not settle");

	// the synced yaw is only ever used once a plan hint and a synced yaw exist
	a_sync_source: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.used_synced) |-> (synced_valid_q && plan_seen_q))
		else $error("synced yaw used without its state");

endmodule
